// ===== sv/iso_date_string_validator_assert.svh =====
// Assertion macros for the ISO date string validator.
// Used by iso_date_string_validator.sv; expects clk and rst_n in scope.
`ifndef ISO_DATE_STRING_VALIDATOR_ASSERT_SVH
`define ISO_DATE_STRING_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IDSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IDSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/idsv_pkg.sv =====
// Package for the ISO date string validator: character codes, positions,
// and the digit and month-length helpers. No dependencies.
package idsv_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  localparam int unsigned POS_W = 4;

  localparam logic [POS_W-1:0] POS_CENT_END  = 4'd2;
  localparam logic [POS_W-1:0] POS_HYPHEN_A  = 4'd4;
  localparam logic [POS_W-1:0] POS_HYPHEN_B  = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST      = 4'd9;
  localparam logic [POS_W-1:0] POS_END       = 4'd10;
  localparam logic [POS_W-1:0] POS_SAT       = 4'd11;

  localparam int unsigned ACC_W   = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;

  localparam logic [ACC_W-1:0] MIN_CENTURY = 7'd10;
  localparam logic [ACC_W-1:0] MONTH_FEB   = 7'd2;
  localparam logic [ACC_W-1:0] MONTH_DEC   = 7'd12;

  typedef logic [ACC_W-1:0] acc_t;

  // acc * 10 + d, kept to the accumulator width
  function automatic acc_t push_digit(input acc_t acc, input logic [3:0] d);
    logic [ACC_W+3:0] sum;
    begin
      sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACC_W{1'b0}}, d};
      return sum[ACC_W-1:0];
    end
  endfunction

  // days in a month 1..12; codes outside that range never pass the month check
  function automatic logic [DAY_W-1:0] month_days(input acc_t month, input logic leap);
    logic [DAY_W-1:0] days;
    begin
      unique case (month)
        7'd2:                      days = leap ? 5'd29 : 5'd28;
        7'd4, 7'd6, 7'd9, 7'd11:   days = 5'd30;
        default:                   days = 5'd31;
      endcase
      return days;
    end
  endfunction

endpackage

// ===== sv/iso_date_string_validator.sv =====
// ISO 8601 date string validator (YYYY-MM-DD), top level.
// Depends on idsv_pkg and iso_date_string_validator_assert.svh.

// Takes one ASCII character per word, with tlast on the final character of a
// string, and returns one result word per string. The result's tuser is
// date_ok: high only if the string was exactly ten characters, had hyphens at
// positions 4 and 7 and digits elsewhere, the year is 1000..9999, the month
// 1..12 and the day within that month under the Gregorian leap rule; otherwise
// tdata is all zero. Throughput is one character per cycle outside the stall
// below: each word is captured in an input register, runs through one shallow
// level of digit accumulation and range checks, and a final character then
// lands in the result register, which offers the result. The input stalls
// only while a final character waits in the input register and the result
// register still holds an untaken word.
module iso_date_string_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [13:0] year_value, [17:14] month_value,
                                  // [22:18] day_value, [23] zero
  output logic        out_tuser   // date_ok
);

  localparam int unsigned PW = idsv_pkg::POS_W;
  localparam int unsigned AW = idsv_pkg::ACC_W;
  localparam int unsigned YW = idsv_pkg::YEAR_W;
  localparam int unsigned MW = idsv_pkg::MONTH_W;
  localparam int unsigned DW = idsv_pkg::DAY_W;

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // string state
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              ferr_r, ferr_nxt;
  idsv_pkg::acc_t    cent_r, cent_nxt;
  idsv_pkg::acc_t    ylow_r, ylow_nxt;
  idsv_pkg::acc_t    mon_r, mon_nxt;
  idsv_pkg::acc_t    day_r, day_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic          ok_r, ok_nxt;
  logic [YW-1:0] year_r, year_nxt;
  logic [MW-1:0] month_r, month_nxt;
  logic [DW-1:0] dayo_r, dayo_nxt;

  logic out_adv, proc, in_acc;

  // Advance the result register when it is empty or being taken; a non-final
  // character never needs it, so let it through regardless.
  assign out_adv   = !out_valid_r || out_tready;
  assign proc      = in_valid_r && (!in_last_r || out_adv);
  assign in_tready = !in_valid_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  assign in_valid_nxt = in_acc ? 1'b1 : (proc ? 1'b0 : in_valid_r);

  // per-character update
  logic           is_digit;
  logic [3:0]     digit;
  logic           leap, ok_calc;
  logic [YW-1:0]  year_calc;
  logic [DW-1:0]  max_day;
  idsv_pkg::acc_t cent_u, ylow_u, mon_u, day_u;
  logic           ferr_u;

  always_comb begin
    is_digit = (in_char_r >= idsv_pkg::CHAR_ZERO) && (in_char_r <= idsv_pkg::CHAR_NINE);
    digit    = 4'(in_char_r - idsv_pkg::CHAR_ZERO);
    cent_u   = cent_r;
    ylow_u   = ylow_r;
    mon_u    = mon_r;
    day_u    = day_r;
    ferr_u   = ferr_r;
    if (pos_r < idsv_pkg::POS_END) begin
      if (pos_r == idsv_pkg::POS_HYPHEN_A || pos_r == idsv_pkg::POS_HYPHEN_B) begin
        if (in_char_r != idsv_pkg::CHAR_HYPHEN) ferr_u = 1'b1;
      end else if (!is_digit) begin
        ferr_u = 1'b1;
      end else if (pos_r < idsv_pkg::POS_CENT_END) begin
        cent_u = idsv_pkg::push_digit(cent_r, digit);
      end else if (pos_r < idsv_pkg::POS_HYPHEN_A) begin
        ylow_u = idsv_pkg::push_digit(ylow_r, digit);
      end else if (pos_r < idsv_pkg::POS_HYPHEN_B) begin
        mon_u = idsv_pkg::push_digit(mon_r, digit);
      end else begin
        day_u = idsv_pkg::push_digit(day_r, digit);
      end
    end

    // With a clean format both halves of the year are below 100, so the leap
    // rule reduces to the low pair, or the century when the low pair is zero.
    leap      = (ylow_u != '0) ? (ylow_u[1:0] == 2'b00) : (cent_u[1:0] == 2'b00);
    max_day   = idsv_pkg::month_days(mon_u, leap && (mon_u == idsv_pkg::MONTH_FEB));
    year_calc = YW'(cent_u) * YW'(100) + YW'(ylow_u);
    ok_calc   = (pos_r == idsv_pkg::POS_LAST) && !ferr_u
             && (cent_u >= idsv_pkg::MIN_CENTURY)
             && (mon_u != '0) && (mon_u <= idsv_pkg::MONTH_DEC)
             && (day_u != '0) && (day_u <= AW'(max_day));
  end

  always_comb begin
    pos_nxt  = pos_r;
    ferr_nxt = ferr_r;
    cent_nxt = cent_r;
    ylow_nxt = ylow_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    if (proc) begin
      if (in_last_r) begin
        // drop the string state, the next word starts a new string
        pos_nxt  = '0;
        ferr_nxt = 1'b0;
        cent_nxt = '0;
        ylow_nxt = '0;
        mon_nxt  = '0;
        day_nxt  = '0;
      end else begin
        pos_nxt  = (pos_r < idsv_pkg::POS_SAT) ? pos_r + PW'(1) : pos_r;
        ferr_nxt = ferr_u;
        cent_nxt = cent_u;
        ylow_nxt = ylow_u;
        mon_nxt  = mon_u;
        day_nxt  = day_u;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    dayo_nxt      = dayo_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (proc && in_last_r) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = ok_calc;
      year_nxt      = ok_calc ? year_calc : '0;
      month_nxt     = ok_calc ? mon_u[MW-1:0] : '0;
      dayo_nxt      = ok_calc ? day_u[DW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      ferr_r      <= 1'b0;
      cent_r      <= '0;
      ylow_r      <= '0;
      mon_r       <= '0;
      day_r       <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      ferr_r      <= ferr_nxt;
      cent_r      <= cent_nxt;
      ylow_r      <= ylow_nxt;
      mon_r       <= mon_nxt;
      day_r       <= day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    ok_r    <= ok_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    dayo_r  <= dayo_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {1'b0, dayo_r, month_r, year_r};

  // terms for the checks below
  logic month_in_range, str_clear;

  assign month_in_range = (month_r != '0) && (month_r <= MW'(idsv_pkg::MONTH_DEC));
  assign str_clear      = (pos_r == '0) && !ferr_r;

`include "iso_date_string_validator_assert.svh"

  `IDSV_ASSERT_NOW(a_month_range, out_tvalid && ok_r, month_in_range, "month out of range")
  `IDSV_ASSERT_NOW(a_bad_is_zero, out_tvalid && !ok_r, out_tdata == '0, "nonzero reject")
  `IDSV_ASSERT_NEXT(a_clear_after_last, proc && in_last_r, str_clear, "state not cleared")

endmodule
